>>> rtl/move_to_front_codec_core_defines.svh
// Assertion macros used by the checker file.
`ifndef MOVE_TO_FRONT_CODEC_CORE_DEFINES_SVH
`define MOVE_TO_FRONT_CODEC_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define MTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define MTF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/mtf_pkg.sv
package mtf_pkg;

  // Symbol width and default alphabet size
  localparam int unsigned SYM_W             = 8;
  localparam int unsigned ALPHABET_SIZE_DEF = 256;

  // Mode register codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic shift;  // take the neighbor's value
    logic ident;  // reload the identity value
  } cell_ctrl_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FIND = 4'b0010,
    ST_MOVE = 4'b0100,
    ST_HOLD = 4'b1000
  } state_e;

endpackage

>>> rtl/mtf_cell.sv
module mtf_cell import mtf_pkg::*; #(
  parameter logic [SYM_W-1:0] RESET_VAL = '0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [SYM_W-1:0] next_i,
  output logic [SYM_W-1:0] val_o
);

  logic [SYM_W-1:0] val_q, val_d;

  // Identity reload wins over a shift step
  always_comb begin
    val_d = val_q;
    if (ctrl_i.ident) begin
      val_d = RESET_VAL;
    end else if (ctrl_i.shift) begin
      val_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= RESET_VAL;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

>>> rtl/mtf_ctrl.sv
module mtf_ctrl import mtf_pkg::*; #(
  parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [SYM_W-1:0] symbol_in_i,
  input  logic             block_last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [SYM_W-1:0] symbol_out_o,
  input  logic [SYM_W-1:0] tail_i,
  output logic [SYM_W-1:0] enter_o,
  output cell_ctrl_t       cell_ctrl_o
);

  localparam int unsigned CNT_W = $clog2(ALPHABET_SIZE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ALPHABET_SIZE - 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             mode_q;
  logic             dec_q, dec_d;
  logic             last_q, last_d;
  logic             active_q, active_d;
  logic [SYM_W-1:0] key_q, key_d;
  logic [SYM_W-1:0] hold_q, hold_d;
  logic [SYM_W-1:0] res_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic [SYM_W-1:0] out_data_q, out_data_d;
  logic             in_range;
  logic             pos_hit;
  logic             pass_end;

  assign in_range = ({1'b0, symbol_in_i} < (SYM_W + 1)'(ALPHABET_SIZE));
  assign pos_hit  = (SYM_W'(cnt_q) == key_q);
  assign pass_end = (cnt_q == CNT_LAST);

  // Sequencer: one full ring rotation per pass
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dec_d       = dec_q;
    last_d      = last_q;
    active_d    = active_q;
    key_d       = key_q;
    hold_d      = hold_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    enter_o     = tail_i;
    cell_ctrl_o = '0;

    // Result taken by the receiver
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          last_d   = block_last_i;
          dec_d    = (mode_q == MODE_DECODE);
          key_d    = symbol_in_i;
          hold_d   = symbol_in_i;
          active_d = 1'b1;
          cnt_d    = '0;
          if (!in_range) begin
            res_d   = '0;
            state_d = ST_HOLD;
          end else if (mode_q == MODE_DECODE) begin
            state_d = ST_FIND;
          end else begin
            state_d = ST_MOVE;
          end
        end
      end

      // Decode: plain rotation, capture the entry at the requested position
      ST_FIND: begin
        cell_ctrl_o.shift = 1'b1;
        if (pos_hit) begin
          res_d  = tail_i;
          hold_d = tail_i;
        end
        if (pass_end) begin
          cnt_d   = '0;
          key_d   = pos_hit ? tail_i : hold_q;
          state_d = ST_MOVE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      // Swap the carried value with each entry up to and including the match
      ST_MOVE: begin
        cell_ctrl_o.shift = 1'b1;
        if (active_q) begin
          enter_o = hold_q;
          hold_d  = tail_i;
          if (tail_i == key_q) begin
            active_d = 1'b0;
            if (!dec_q) begin
              res_d = SYM_W'(cnt_q);
            end
          end
        end
        if (pass_end) begin
          cnt_d   = '0;
          state_d = ST_HOLD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      // Wait for a free output register, then restart the list at block end
      ST_HOLD: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_data_d        = res_q;
          cell_ctrl_o.ident = last_q;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      mode_q      <= MODE_ENCODE;
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      active_q    <= active_d;
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dec_q      <= dec_d;
    last_q     <= last_d;
    key_q      <= key_d;
    hold_q     <= hold_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign symbol_out_o = out_data_q;

endmodule

>>> rtl/move_to_front_codec_core.sv
// Move-to-front coder, one byte transaction in, one byte transaction out.
// Input channel: in_valid_i / in_stall_o carry symbol_in_i and block_last_i.
// Output channel: out_valid_o / out_stall_i carry symbol_out_o.
// cfg_we_i writes cfg_data_i into the mode register (0 encode, 1 decode);
// write it only while no transaction is in flight.
// The recency list lives in a ring of ALPHABET_SIZE cells. Each pass rotates
// the ring once, one cell step per cycle.
// Encode takes one pass, decode two (locate the entry, then move it).
// A symbol outside the alphabet skips the passes, and its result is 0.
// One transaction is in flight at a time; the next can be accepted in the
// cycle after the result is loaded into the output register.
// While the receiver stalls, the result holds in the output register and the
// block finishes the next transaction up to its result, then waits.
// Reset sets the list to identity and the mode to encode. After a transaction
// with block_last_i set, the list returns to identity as its result is loaded.
module move_to_front_codec_core import mtf_pkg::*; #(
  parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [SYM_W-1:0] symbol_in_i,
  input  logic             block_last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [SYM_W-1:0] symbol_out_o
);

  logic [SYM_W-1:0] cell_val [ALPHABET_SIZE];
  logic [SYM_W-1:0] enter;
  cell_ctrl_t       cell_ctrl;

  // Sequencer
  mtf_ctrl #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .symbol_in_i (symbol_in_i),
    .block_last_i(block_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .symbol_out_o(symbol_out_o),
    .tail_i      (cell_val[0]),
    .enter_o     (enter),
    .cell_ctrl_o (cell_ctrl)
  );

  // Ring of list cells: cell 0 is the tail, new entries enter at the top
  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
    logic [SYM_W-1:0] next_val;
    if (i == ALPHABET_SIZE - 1) begin : g_top
      assign next_val = enter;
    end else begin : g_mid
      assign next_val = cell_val[i + 1];
    end
    mtf_cell #(
      .RESET_VAL(SYM_W'(i))
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(cell_ctrl),
      .next_i(next_val),
      .val_o (cell_val[i])
    );
  end

endmodule

>>> rtl/mtf_checker.sv
`include "move_to_front_codec_core_defines.svh"

module mtf_checker import mtf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [SYM_W-1:0] symbol_out_o
);

  // A stalled result stays put
  `MTF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
                   out_valid_o && out_stall_i, out_valid_o && $stable(symbol_out_o))

  // An accepted transaction closes the input until its result is out
  `MTF_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni,
                   in_valid_i && !in_stall_o, in_stall_o)

  // A new result only appears from a transaction in flight
  `MTF_ASSERT_SAME(a_result_source, clk_i, rst_ni,
                   $rose(out_valid_o), $past(in_stall_o))

endmodule

bind move_to_front_codec_core mtf_checker u_mtf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .symbol_out_o(symbol_out_o)
);

>>> test/mtf_codec_checker.sv
`timescale 1ns / 1ps

module mtf_codec_checker import mtf_pkg::*; #(
  parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [SYM_W-1:0] symbol_in_i,
  input  logic             block_last_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [SYM_W-1:0] symbol_out_i,
  output int               fail_count_o,
  output int               pending_o
);

  // Shadow copy of the recency list and the mode register
  logic [SYM_W-1:0] recency [ALPHABET_SIZE];
  logic             mode_q;

  // Coded symbols waiting for their output transaction, oldest first
  logic [SYM_W-1:0] coded_q [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic void restore_identity();
    int i;
    for (i = 0; i < ALPHABET_SIZE; i++) begin
      recency[i] = i[SYM_W-1:0];
    end
  endfunction

  // Code one symbol against the list, then move it to the front
  function automatic logic [SYM_W-1:0] mtf_code(input logic [SYM_W-1:0] sym,
                                                input logic             last);
    int               pos;
    int               i;
    logic [SYM_W-1:0] front;
    logic [SYM_W-1:0] coded;
    coded = '0;
    pos   = -1;
    if (sym < ALPHABET_SIZE) begin
      if (mode_q == MODE_ENCODE) begin
        for (i = 0; i < ALPHABET_SIZE; i++) begin
          if (pos < 0 && recency[i] == sym) pos = i;
        end
        if (pos >= 0) coded = pos[SYM_W-1:0];
      end else begin
        pos   = sym;
        coded = recency[sym];
      end
      if (pos >= 0) begin
        front = recency[pos];
        for (i = pos; i > 0; i--) begin
          recency[i] = recency[i-1];
        end
        recency[0] = front;
      end
    end
    // End of block: list goes back to identity, even for unmatched items
    if (last) restore_identity();
    return coded;
  endfunction

  // Watch both channels and the config port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restore_identity();
      mode_q = MODE_ENCODE;
      coded_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) mode_q = cfg_data_i;
      // output transaction: compare with the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (coded_q.size() == 0) begin
          $error("symbol_out: unexpected transaction, expected none, actual %0d",
                 symbol_out_i);
          fail_count_o++;
        end else if (symbol_out_i !== coded_q[0]) begin
          $error("symbol_out mismatch: expected %0d, actual %0d",
                 coded_q[0], symbol_out_i);
          fail_count_o++;
          void'(coded_q.pop_front());
        end else begin
          void'(coded_q.pop_front());
        end
      end
      // input transaction: predict its result
      if (in_valid_i && !in_stall_i) begin
        coded_q.push_back(mtf_code(symbol_in_i, block_last_i));
      end
      pending_o = coded_q.size();
    end
  end

endmodule

>>> test/tb_move_to_front_codec_core.sv
`timescale 1ns / 1ps

module tb_move_to_front_codec_core;
  import mtf_pkg::*;

  localparam int unsigned ALPHA        = ALPHABET_SIZE_DEF;
  localparam int          CYCLE_LIMIT  = 1_500_000;
  localparam int          PHASE_ITEMS  = 60;
  localparam int          DRAIN_CYCLES = 2 * ALPHA + 16;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             cfg_we       = 1'b0;
  logic             cfg_data     = MODE_ENCODE;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [SYM_W-1:0] symbol_in    = '0;
  logic             block_last   = 1'b0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [SYM_W-1:0] symbol_out;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int cycle_count   = 0;
  int fail_count;
  int pending;

  move_to_front_codec_core #(
    .ALPHABET_SIZE(ALPHA)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .symbol_in_i (symbol_in),
    .block_last_i(block_last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .symbol_out_o(symbol_out)
  );

  mtf_codec_checker #(
    .ALPHABET_SIZE(ALPHA)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .symbol_in_i (symbol_in),
    .block_last_i(block_last),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .symbol_out_i(symbol_out),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver backpressure
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_move_to_front_codec_core NOT OK");
      $finish;
    end
  end

  // Present one transaction, return at the edge where it is accepted
  task automatic send_item(input logic [SYM_W-1:0] sym, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    symbol_in  <= sym;
    block_last <= last;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Drain all results, then write the mode register
  task automatic write_mode(input logic m);
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Random symbol: mixes full range, front-of-list values and top values
  task automatic send_random();
    logic [SYM_W-1:0] sym;
    logic             last;
    case ($urandom_range(3))
      0: sym = SYM_W'($urandom_range(255));
      1: sym = SYM_W'($urandom_range(7));
      2: sym = SYM_W'(255 - $urandom_range(3));
      default: sym = SYM_W'($urandom_range(31));
    endcase
    last = ($urandom_range(31) == 0);
    send_item(sym, last);
  endtask

  initial begin
    int p;
    int n;
    int profile;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: encode from the reset mode, extremes and end of block
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd128, 1'b0);
    send_item(8'd7, 1'b1);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b1);
    send_item(8'd1, 1'b0);
    send_item(8'd0, 1'b0);

    // Directed: decode, extremes and end of block
    write_mode(MODE_DECODE);
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd1, 1'b0);
    send_item(8'd200, 1'b1);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b1);
    send_item(8'd3, 1'b0);

    // Random phases: each idle profile in both modes
    for (p = 0; p < 8; p++) begin
      write_mode(((p + p / 4) % 2) ? MODE_DECODE : MODE_ENCODE);
      profile = p % 4;
      case (profile)
        0: begin in_idle_pct = 0;  out_stall_pct <= 0;  end
        1: begin in_idle_pct = 87; out_stall_pct <= 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct <= 87; end
        default: begin in_idle_pct = 21; out_stall_pct <= 21; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_random();
      end
    end

    // Drain and watch for stray results
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("tb_move_to_front_codec_core OK");
    end else begin
      $display("tb_move_to_front_codec_core NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/mtf_pkg.sv
rtl/mtf_cell.sv
rtl/mtf_ctrl.sv
rtl/move_to_front_codec_core.sv
rtl/mtf_checker.sv
test/mtf_codec_checker.sv
test/tb_move_to_front_codec_core.sv
